FILE: rtl/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared command codes and constants of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

    typedef enum logic {
        OP_BEGIN = 1'b0,
        OP_NEXT  = 1'b1
    } opcode_t;

    localparam int DEC_INIT    = 3;
    localparam int DEC_STEP_E  = 6;
    localparam int DEC_STEP_SE = 10;

    localparam int POINTS_PER_STEP = 8;
    localparam int QUEUE_DEPTH     = 2;

endpackage

FILE: rtl/midpoint_circle_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit
// Midpoint circle rasterizer with eightfold symmetry and a decoupled back end.
// ----------------------------------------------------------------------------
// A begin command is taken and produces no beat. Each next command is
// also taken, stepping the decision value at once, and is queued; the
// back end then delivers eight point beats, one per cycle while pix_ready
// is high, or a single completion beat once the circle is done. The back
// end has a single point adder pair and output register; commands keep
// being taken while the two-entry queue has room. Points with a negative
// coordinate are flagged as not visible, and seam duplicates are kept.
module midpoint_circle_rasterizer_unit #(
    parameter int RADIUS_BITS = 12,
    parameter int COORD_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic                          opcode,
    input  logic signed [COORD_BITS-1:0]  center_x,
    input  logic signed [COORD_BITS-1:0]  center_y,
    input  logic        [RADIUS_BITS-1:0] radius,
    output logic                          pix_valid,
    input  logic                          pix_ready,
    output logic signed [COORD_BITS:0]    pixel_x,
    output logic signed [COORD_BITS:0]    pixel_y,
    output logic                          visible,
    output logic                          finished,
    output logic                          last_of_run
);

    localparam int JOB_W = 1 + 2 * COORD_BITS + 2 * (RADIUS_BITS + 1);

    logic             q_full;
    logic             q_push;
    logic [JOB_W-1:0] q_push_data;
    logic             q_pop;
    logic             q_head_valid;
    logic [JOB_W-1:0] q_head_data;

    mcr_front #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS),
        .JOB_W       (JOB_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .opcode     (opcode),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .queue_full (q_full),
        .queue_push (q_push),
        .queue_data (q_push_data)
    );

    mcr_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    mcr_back #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS),
        .JOB_W       (JOB_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_head_valid),
        .job_data    (q_head_data),
        .job_pop     (q_pop),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .visible     (visible),
        .finished    (finished),
        .last_of_run (last_of_run)
    );

endmodule

FILE: rtl/mcr_queue.sv
// ----------------------------------------------------------------------------
// mcr_queue
// Short first-in first-out queue that carries jobs from the front to the back.
// ----------------------------------------------------------------------------
module mcr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int DEPTH = mcr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/mcr_front.sv
// ----------------------------------------------------------------------------
// mcr_front
// Accepts commands, holds the circle state and steps the decision value,
// handing one job per next command to the queue.
// ----------------------------------------------------------------------------
module mcr_front #(
    parameter int RADIUS_BITS = 12,
    parameter int COORD_BITS  = 16,
    parameter int JOB_W       = 1 + 2 * COORD_BITS + 2 * (RADIUS_BITS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic                          opcode,
    input  logic signed [COORD_BITS-1:0]  center_x,
    input  logic signed [COORD_BITS-1:0]  center_y,
    input  logic        [RADIUS_BITS-1:0] radius,
    input  logic                          queue_full,
    output logic                          queue_push,
    output logic [JOB_W-1:0]              queue_data
);

    localparam int OFF_W = RADIUS_BITS + 1;
    localparam int DEC_W = RADIUS_BITS + 6;

    typedef struct packed {
        logic                   fin;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [OFF_W-1:0]      ox;
        logic signed [OFF_W-1:0]      oy;
    } job_t;

    job_t                         job;
    logic                         accept;
    logic signed [COORD_BITS-1:0] cx_reg;
    logic signed [COORD_BITS-1:0] cy_reg;
    logic signed [OFF_W-1:0]      ox_reg;
    logic signed [OFF_W-1:0]      ox_next;
    logic signed [OFF_W-1:0]      oy_reg;
    logic signed [OFF_W-1:0]      oy_next;
    logic signed [DEC_W-1:0]      dec_reg;
    logic signed [DEC_W-1:0]      dec_next;
    logic                         drawing_reg;

    assign cmd_ready  = !queue_full;
    assign accept     = cmd_valid && cmd_ready;
    assign queue_push = accept && (opcode == mcr_pkg::OP_NEXT);

    assign job.fin    = !drawing_reg;
    assign job.cx     = cx_reg;
    assign job.cy     = cy_reg;
    assign job.ox     = ox_reg;
    assign job.oy     = oy_reg;
    assign queue_data = job;

    always_comb
    begin
        ox_next = ox_reg + OFF_W'(1);
        oy_next = oy_reg;
        if (dec_reg[DEC_W-1])
        begin
            dec_next = dec_reg + (DEC_W'(ox_reg) <<< 2) + DEC_W'(mcr_pkg::DEC_STEP_E);
        end
        else
        begin
            oy_next  = oy_reg - OFF_W'(1);
            dec_next = dec_reg + ((DEC_W'(ox_reg) - DEC_W'(oy_next)) <<< 2)
                     + DEC_W'(mcr_pkg::DEC_STEP_SE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg      <= '0;
            cy_reg      <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            dec_reg     <= '0;
            drawing_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (opcode == mcr_pkg::OP_BEGIN)
            begin
                cx_reg      <= center_x;
                cy_reg      <= center_y;
                ox_reg      <= '0;
                oy_reg      <= OFF_W'(radius);
                dec_reg     <= DEC_W'(mcr_pkg::DEC_INIT) - (DEC_W'(radius) << 1);
                drawing_reg <= 1'b1;
            end
            else if (drawing_reg)
            begin
                ox_reg      <= ox_next;
                oy_reg      <= oy_next;
                dec_reg     <= dec_next;
                drawing_reg <= !(ox_next > oy_next);
            end
        end
    end

endmodule

FILE: rtl/mcr_back.sv
// ----------------------------------------------------------------------------
// mcr_back
// Expands each queued job into its eight mirrored points, or one completion
// beat, through a registered output stage.
// ----------------------------------------------------------------------------
module mcr_back #(
    parameter int RADIUS_BITS = 12,
    parameter int COORD_BITS  = 16,
    parameter int JOB_W       = 1 + 2 * COORD_BITS + 2 * (RADIUS_BITS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    input  logic [JOB_W-1:0]             job_data,
    output logic                         job_pop,
    output logic                         pix_valid,
    input  logic                         pix_ready,
    output logic signed [COORD_BITS:0]   pixel_x,
    output logic signed [COORD_BITS:0]   pixel_y,
    output logic                         visible,
    output logic                         finished,
    output logic                         last_of_run
);

    localparam int OFF_W = RADIUS_BITS + 1;
    localparam int PIX_W = COORD_BITS + 1;
    localparam int SUM_W = ((COORD_BITS > OFF_W) ? COORD_BITS : OFF_W) + 2;
    localparam int K_W   = $clog2(mcr_pkg::POINTS_PER_STEP);

    typedef struct packed {
        logic                   fin;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [OFF_W-1:0]      ox;
        logic signed [OFF_W-1:0]      oy;
    } job_t;

    job_t                    job;
    logic                    load;
    logic                    last_point;
    logic [K_W-1:0]          k_reg;
    logic signed [SUM_W-1:0] off_a;
    logic signed [SUM_W-1:0] off_b;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic                    valid_reg;
    logic [PIX_W-1:0]        px_reg;
    logic [PIX_W-1:0]        py_reg;
    logic                    vis_reg;
    logic                    fin_reg;
    logic                    last_reg;

    assign job        = job_t'(job_data);
    assign load       = job_valid && (!valid_reg || pix_ready);
    assign last_point = (k_reg == K_W'(mcr_pkg::POINTS_PER_STEP - 1));
    assign job_pop    = load && (job.fin || last_point);

    always_comb
    begin
        off_a = k_reg[2] ? SUM_W'(job.oy) : SUM_W'(job.ox);
        off_b = k_reg[2] ? SUM_W'(job.ox) : SUM_W'(job.oy);
        sum_x = k_reg[1] ? SUM_W'(job.cx) - off_a : SUM_W'(job.cx) + off_a;
        sum_y = k_reg[0] ? SUM_W'(job.cy) - off_b : SUM_W'(job.cy) + off_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                k_reg     <= (job.fin || last_point) ? '0 : k_reg + 1'b1;
            end
            else if (pix_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (job.fin)
            begin
                px_reg   <= '0;
                py_reg   <= '0;
                vis_reg  <= 1'b0;
                fin_reg  <= 1'b1;
                last_reg <= 1'b1;
            end
            else
            begin
                px_reg   <= sum_x[PIX_W-1:0];
                py_reg   <= sum_y[PIX_W-1:0];
                vis_reg  <= !sum_x[SUM_W-1] && !sum_y[SUM_W-1];
                fin_reg  <= 1'b0;
                last_reg <= last_point;
            end
        end
    end

    assign pix_valid   = valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign visible     = vis_reg;
    assign finished    = fin_reg;
    assign last_of_run = last_reg;

endmodule
